// File: hw/rtl/hp_pkg.sv
// shared constants, types and helpers for the histogram percentile block
`default_nettype none

package hp_pkg;

  localparam int unsigned BIN_COUNT  = 256;
  localparam int unsigned BIN_W      = $clog2(BIN_COUNT);
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned PROD_W     = FRAC_W + COUNT_BITS;
  localparam int unsigned TOTAL_W    = 24;

  typedef logic [BIN_W-1:0]      bin_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [FRAC_W-1:0]     frac_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [TOTAL_W-1:0]    total_t;

  localparam bin_t   BIN_MAX   = BIN_W'(BIN_COUNT - 1);
  localparam frac_t  Q_ONE     = FRAC_W'(65536);
  localparam total_t TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PIXEL = 2'd1,
    OP_QUERY = 2'd2
  } hp_op_e;

  // one access slot of the bin memory
  typedef struct packed {
    logic   rd_en;
    bin_t   rd_addr;
    logic   wr_en;
    bin_t   wr_addr;
    count_t wr_data;
    logic   clear;
  } hp_mem_req_t;

  // read request from the query walker
  typedef struct packed {
    logic rd_en;
    bin_t rd_addr;
  } hp_walk_rd_t;

  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (&v) ? v : v + count_t'(1);
    return r;
  endfunction

  function automatic total_t total_out(input count_t t);
    logic [31:0] w;
    total_t      r;
    w = 32'(t);
    r = (w > 32'(TOTAL_MAX)) ? TOTAL_MAX : w[TOTAL_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/histogram_percentile.sv
// top level of the 256-bin pixel histogram with percentile queries
// results: pixel and clear items give no result; a query result is found by the bin walk
//   reading one memory entry per cycle, then waits while the result side is held
// input: one pixel or clear item per cycle while no query is in flight; a query holds
//   the input stalled until its result has entered the output register, which takes
//   longer while a previous result is held stalled
// reset: asynchronous, active low; all bins and the total read as zero afterwards
//   through per-bin valid bits, so no clearing pass is needed
`default_nettype none

module histogram_percentile (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // input item channel
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  [1:0]            opcode_i,
  input  hp_pkg::bin_t          pixel_i,
  input  hp_pkg::frac_t         fraction_i,
  // result item channel
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output hp_pkg::bin_t          bin_index_o,
  output hp_pkg::total_t        pixel_total_o
);
  import hp_pkg::*;

  // item decode
  logic        in_acc;
  logic        pix_acc;
  logic        clr_acc;
  logic        qry_acc;
  frac_t       frac_clamped;

  // pixel read-modify-write pipeline: the read goes out at acceptance,
  // the incremented count is written back in the cycle after
  logic        pix_b_q;
  bin_t        pix_addr_q;
  count_t      pix_base;
  count_t      pix_new;

  // last write, kept for forwarding to a back-to-back pixel on the same bin
  logic        wr_vld_q;
  bin_t        wr_addr_q;
  count_t      wr_data_q;

  count_t      total_q;
  count_t      rd_count;
  hp_mem_req_t mem_req;
  hp_walk_rd_t walk_rd;
  logic        q_busy;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign pix_acc = in_acc && (opcode_i == OP_PIXEL);
  assign clr_acc = in_acc && (opcode_i == OP_CLEAR);
  assign qry_acc = in_acc && (opcode_i == OP_QUERY);

  // fractions above one count as one
  assign frac_clamped = fraction_i[FRAC_W-1] ? Q_ONE : fraction_i;

  // the memory was written at the previous edge for the previous pixel,
  // so a match on that address takes the written value instead of the stale read
  assign pix_base = (wr_vld_q && wr_addr_q == pix_addr_q) ? wr_data_q : rd_count;
  assign pix_new  = sat_inc(pix_base);

  // the walk only reads while the input is stalled, so the two never collide
  always_comb begin
    mem_req         = '0;
    mem_req.rd_en   = pix_acc || walk_rd.rd_en;
    mem_req.rd_addr = walk_rd.rd_en ? walk_rd.rd_addr : pixel_i;
    mem_req.wr_en   = pix_b_q;
    mem_req.wr_addr = pix_addr_q;
    mem_req.wr_data = pix_new;
    mem_req.clear   = clr_acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_b_q  <= 1'b0;
      wr_vld_q <= 1'b0;
      total_q  <= '0;
    end else begin
      pix_b_q <= pix_acc;
      // a clear in the same cycle as a write-back discards that write
      wr_vld_q <= pix_b_q && !clr_acc;
      if (clr_acc) begin
        total_q <= '0;
      end else if (pix_acc) begin
        total_q <= sat_inc(total_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      pix_addr_q <= pixel_i;
    end
    wr_addr_q <= pix_addr_q;
    wr_data_q <= pix_new;
  end

  hp_bin_mem u_bin_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .rd_count_o (rd_count)
  );

  hp_query u_query (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (qry_acc),
    .frac_i        (frac_clamped),
    .total_i       (total_q),
    .rd_count_i    (rd_count),
    .walk_rd_o     (walk_rd),
    .busy_o        (q_busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .bin_index_o   (bin_index_o),
    .pixel_total_o (pixel_total_o)
  );

  // the input waits while a query is in flight
  assign in_stall_o = q_busy;

  // a pixel write-back never shares its cycle with a walk read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_b_q |-> !walk_rd.rd_en)
    else $error("pixel write-back overlaps bin walk");

  // a clear empties the total at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_acc |=> (total_q == '0))
    else $error("total not cleared");

  // an accepted query holds the input off on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qry_acc |=> in_stall_o)
    else $error("input not stalled after query");

endmodule

`default_nettype wire

// File: hw/rtl/hp_bin_mem.sv
// bin count memory with per-entry valid bits and registered read
`default_nettype none

module hp_bin_mem (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  hp_pkg::hp_mem_req_t req_i,
  output hp_pkg::count_t      rd_count_o
);
  import hp_pkg::*;

  count_t                 mem [BIN_COUNT];
  logic   [BIN_COUNT-1:0] valid_q;
  count_t                 rd_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  // a clear drops every entry at once, after any write in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_vld_q <= valid_q[req_i.rd_addr];
      end
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_count_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

// File: hw/rtl/hp_query.sv
// percentile query sequencer: target product, bin walk and result register
`default_nettype none

module hp_query (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  hp_pkg::frac_t       frac_i,
  input  hp_pkg::count_t      total_i,
  input  hp_pkg::count_t      rd_count_i,
  output hp_pkg::hp_walk_rd_t walk_rd_o,
  output logic                busy_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output hp_pkg::bin_t        bin_index_o,
  output hp_pkg::total_t      pixel_total_o
);
  import hp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WALK  = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  prod_t  prod_q;
  count_t rem_q, rem_d;
  bin_t   idx_q, idx_d;
  bin_t   res_q, res_d;
  total_t tot_q;
  logic   out_valid_q, out_valid_d;
  bin_t   out_bin_q;
  total_t out_tot_q;
  count_t target;
  logic   load_out;

  assign target = prod_q[FRAC_SHIFT +: COUNT_BITS];

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    res_d       = res_q;
    walk_rd_o   = '0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_START;
        end
      end
      S_START: begin
        if (target == '0) begin
          res_d   = BIN_MAX;
          state_d = S_OUT;
        end else begin
          walk_rd_o.rd_en   = 1'b1;
          walk_rd_o.rd_addr = '0;
          idx_d             = '0;
          rem_d             = target;
          state_d           = S_WALK;
        end
      end
      S_WALK: begin
        if (rd_count_i >= rem_q) begin
          // nearer the end of the previous bin when 2*rem < count
          if (idx_q != '0 && {rem_q, 1'b0} < {1'b0, rd_count_i}) begin
            res_d = idx_q - bin_t'(1);
          end else begin
            res_d = idx_q;
          end
          state_d = S_OUT;
        end else if (idx_q == BIN_MAX) begin
          res_d   = BIN_MAX;
          state_d = S_OUT;
        end else begin
          walk_rd_o.rd_en   = 1'b1;
          walk_rd_o.rd_addr = idx_q + bin_t'(1);
          idx_d             = idx_q + bin_t'(1);
          rem_d             = rem_q - rd_count_i;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == S_IDLE) begin
      prod_q <= PROD_W'(frac_i) * PROD_W'(total_i);
      tot_q  <= total_out(total_i);
    end
    rem_q <= rem_d;
    idx_q <= idx_d;
    res_q <= res_d;
    if (load_out) begin
      out_bin_q <= res_q;
      out_tot_q <= tot_q;
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign bin_index_o   = out_bin_q;
  assign pixel_total_o = out_tot_q;

endmodule

`default_nettype wire
